[rtl/ptc_pkg.sv]
// Shared types and constants for the pressure/temperature compensation pipeline.
// Used by ptc_front, ptc_corr, ptc_press and pressure_temp_compensation_unit.
// No dependencies.
`timescale 1ns / 1ps

package ptc_pkg;

    // Port widths
    localparam int RAW_W    = 24;
    localparam int CAL_W    = 16;
    localparam int OUT_W    = 32;
    localparam int CFG_IDX_W = 3;

    // Internal widths
    localparam int DT_W     = 25;   // raw temperature minus reference
    localparam int P1_W     = 42;   // dT times a calibration word
    localparam int DT2_W    = 48;   // dT squared
    localparam int TEMP_W   = 20;   // first-order temperature and deviations
    localparam int OFF_W    = 40;   // first-order offset and sensitivity
    localparam int TI_W     = 17;   // second-order temperature term
    localparam int SQ_W     = 40;   // squared temperature deviations
    localparam int CORR_W   = 42;   // second-order offset/sensitivity terms
    localparam int TOUT_W   = 21;   // final temperature
    localparam int ADJ_W    = 42;   // corrected offset and sensitivity
    localparam int PP_LO_W  = 45;   // low partial product
    localparam int PP_HI_W  = 46;   // high partial product
    localparam int PROD_W   = 67;   // full pressure product
    localparam int Q2_W     = 46;   // product over 2^21
    localparam int V_W      = 47;   // scaled product minus offset
    localparam int PRES_W   = 34;   // pressure before saturation

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SENS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TCS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TCO      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TREF     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPSENS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL    = 3'd6;

    // Sensor range codes
    localparam logic MODEL_HIGH_RANGE = 1'b0;   // thirty bar part
    localparam logic MODEL_LOW_RANGE  = 1'b1;   // two bar part

    // Temperature offsets in centidegrees
    localparam logic signed [TEMP_W-1:0] TEMP_REF = 20'sd2000;
    localparam logic signed [TEMP_W-1:0] VLOW_OFS = 20'sd3500;   // 2000 + 1500

    // Calibration set held in the configuration registers
    typedef struct packed {
        logic [CAL_W-1:0] sens;
        logic [CAL_W-1:0] offset;
        logic [CAL_W-1:0] tcs;
        logic [CAL_W-1:0] tco;
        logic [CAL_W-1:0] tref;
        logic [CAL_W-1:0] tempsens;
        logic             model;
    } ptc_cal_t;

    // First-order results handed to the correction stages
    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [TEMP_W-1:0] dev;    // temp - 2000
        logic signed [TEMP_W-1:0] tlow;   // temp + 1500
        logic                     cold;   // temp < 2000
        logic                     vcold;  // temp < -1500
        logic signed [OFF_W-1:0]  off;
        logic signed [OFF_W-1:0]  sens;
        logic [DT2_W-1:0]         dt2;
    } ptc_front_t;

    // Corrected terms handed to the pressure stages
    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TOUT_W-1:0] temp_out;
        logic signed [ADJ_W-1:0]  sens_adj;
        logic signed [ADJ_W-1:0]  off_adj;
    } ptc_corr_t;

endpackage

[rtl/ptc_front.sv]
// First-order stages: temperature difference, calibration products, TEMP/OFF/SENS.
// Three register stages. Depends on ptc_pkg.
`timescale 1ns / 1ps

module ptc_front
    import ptc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [RAW_W-1:0] d1_in,
    input  logic [RAW_W-1:0] d2_in,
    input  ptc_cal_t         cal,
    output logic             fo_valid,
    output ptc_front_t       fo
);

    localparam logic signed [P1_W-1:0] BIAS_23 = 42'sd8388607;
    localparam logic signed [P1_W-1:0] BIAS_8  = 42'sd255;
    localparam logic signed [P1_W-1:0] BIAS_7  = 42'sd127;
    localparam logic signed [P1_W-1:0] BIAS_6  = 42'sd63;
    localparam logic signed [P1_W-1:0] ZERO_P1 = 42'sd0;

    logic                    s1_valid_reg;
    logic [RAW_W-1:0]        s1_d1_reg;
    logic signed [DT_W-1:0]  s1_dt_reg;
    logic signed [DT_W-1:0]  s1_dt_next;

    logic                    s2_valid_reg;
    logic [RAW_W-1:0]        s2_d1_reg;
    logic signed [P1_W-1:0]  s2_ptemp_reg;
    logic signed [P1_W-1:0]  s2_ptco_reg;
    logic signed [P1_W-1:0]  s2_ptcs_reg;
    logic [DT2_W-1:0]        s2_dt2_reg;
    logic signed [P1_W-1:0]  s2_ptemp_next;
    logic signed [P1_W-1:0]  s2_ptco_next;
    logic signed [P1_W-1:0]  s2_ptcs_next;
    logic signed [2*DT_W-1:0] s2_dt2_full;

    logic                    fo_valid_reg;
    ptc_front_t              fo_reg;
    ptc_front_t              fo_next;

    logic signed [P1_W-1:0]  ptemp_b;
    logic signed [P1_W-1:0]  ptemp_q;
    logic signed [P1_W-1:0]  tco_q7;
    logic signed [P1_W-1:0]  tco_q6;
    logic signed [P1_W-1:0]  tcs_q8;
    logic signed [P1_W-1:0]  tcs_q7;
    logic signed [TEMP_W-1:0] q_t;

    // Stage 1: temperature difference against the reference word
    assign s1_dt_next = $signed({1'b0, d2_in}) - $signed({1'b0, cal.tref, 8'b0});

    // Stage 2: dT against the calibration coefficients, and dT squared
    assign s2_ptemp_next = s1_dt_reg * $signed({1'b0, cal.tempsens});
    assign s2_ptco_next  = s1_dt_reg * $signed({1'b0, cal.tco});
    assign s2_ptcs_next  = s1_dt_reg * $signed({1'b0, cal.tcs});
    assign s2_dt2_full   = s1_dt_reg * s1_dt_reg;

    // Stage 3: truncating shifts, then first-order temperature, offset, sensitivity
    always_comb
    begin
        ptemp_b = s2_ptemp_reg + (s2_ptemp_reg[P1_W-1] ? BIAS_23 : ZERO_P1);
        ptemp_q = ptemp_b >>> 23;
        tco_q7  = (s2_ptco_reg + (s2_ptco_reg[P1_W-1] ? BIAS_7 : ZERO_P1)) >>> 7;
        tco_q6  = (s2_ptco_reg + (s2_ptco_reg[P1_W-1] ? BIAS_6 : ZERO_P1)) >>> 6;
        tcs_q8  = (s2_ptcs_reg + (s2_ptcs_reg[P1_W-1] ? BIAS_8 : ZERO_P1)) >>> 8;
        tcs_q7  = (s2_ptcs_reg + (s2_ptcs_reg[P1_W-1] ? BIAS_7 : ZERO_P1)) >>> 7;
        q_t     = ptemp_q[TEMP_W-1:0];

        fo_next.d1    = s2_d1_reg;
        fo_next.dev   = q_t;
        fo_next.temp  = q_t + TEMP_REF;
        fo_next.tlow  = q_t + VLOW_OFS;
        fo_next.cold  = q_t[TEMP_W-1];
        fo_next.vcold = fo_next.tlow[TEMP_W-1];
        fo_next.dt2   = s2_dt2_reg;
        if (cal.model == MODEL_LOW_RANGE)
        begin
            fo_next.off  = $signed({7'b0, cal.offset, 17'b0}) + tco_q6[OFF_W-1:0];
            fo_next.sens = $signed({8'b0, cal.sens, 16'b0}) + tcs_q7[OFF_W-1:0];
        end
        else
        begin
            fo_next.off  = $signed({8'b0, cal.offset, 16'b0}) + tco_q7[OFF_W-1:0];
            fo_next.sens = $signed({9'b0, cal.sens, 15'b0}) + tcs_q8[OFF_W-1:0];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            fo_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            fo_valid_reg <= s2_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        s1_d1_reg    <= d1_in;
        s1_dt_reg    <= s1_dt_next;
        s2_d1_reg    <= s1_d1_reg;
        s2_ptemp_reg <= s2_ptemp_next;
        s2_ptco_reg  <= s2_ptco_next;
        s2_ptcs_reg  <= s2_ptcs_next;
        s2_dt2_reg   <= s2_dt2_full[DT2_W-1:0];
        fo_reg       <= fo_next;
    end

    assign fo_valid = fo_valid_reg;
    assign fo       = fo_reg;

endmodule

[rtl/ptc_corr.sv]
// Second-order stages: squared deviations, low and very-low temperature terms,
// corrected offset and sensitivity. Three register stages. Depends on ptc_pkg.
`timescale 1ns / 1ps

module ptc_corr
    import ptc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fo_valid,
    input  ptc_front_t fo,
    input  logic       model,
    output logic       co_valid,
    output ptc_corr_t  co
);

    logic                     s4_valid_reg;
    logic [RAW_W-1:0]         s4_d1_reg;
    logic signed [TEMP_W-1:0] s4_temp_reg;
    logic [TI_W-1:0]          s4_ti_reg;
    logic [SQ_W-1:0]          s4_dev2_reg;
    logic [SQ_W-1:0]          s4_low2_reg;
    logic                     s4_cold_reg;
    logic                     s4_vcold_reg;
    logic signed [OFF_W-1:0]  s4_off_reg;
    logic signed [OFF_W-1:0]  s4_sens_reg;
    logic [TI_W-1:0]          s4_ti_next;
    logic signed [SQ_W-1:0]   s4_dev2_next;
    logic signed [SQ_W-1:0]   s4_low2_next;
    logic [DT2_W+1:0]         dt2_x3;
    logic [DT2_W+3:0]         dt2_x11;

    logic                     s5_valid_reg;
    logic [RAW_W-1:0]         s5_d1_reg;
    logic signed [TOUT_W-1:0] s5_tout_reg;
    logic [CORR_W-1:0]        s5_offi_reg;
    logic [CORR_W-1:0]        s5_sensi_reg;
    logic signed [OFF_W-1:0]  s5_off_reg;
    logic signed [OFF_W-1:0]  s5_sens_reg;
    logic signed [TOUT_W-1:0] s5_tout_next;
    logic [CORR_W-1:0]        s5_offi_next;
    logic [CORR_W-1:0]        s5_sensi_next;
    logic [CORR_W-1:0]        dv;
    logic [CORR_W-1:0]        lw;

    logic                     co_valid_reg;
    ptc_corr_t                co_reg;
    ptc_corr_t                co_next;

    // Stage 4: squares and the second-order temperature term
    assign s4_dev2_next = fo.dev * fo.dev;
    assign s4_low2_next = fo.tlow * fo.tlow;

    always_comb
    begin
        dt2_x3  = {1'b0, fo.dt2, 1'b0} + {2'b0, fo.dt2};
        dt2_x11 = {1'b0, fo.dt2, 3'b0} + {3'b0, fo.dt2, 1'b0} + {4'b0, fo.dt2};
        if (model == MODEL_LOW_RANGE)
        begin
            s4_ti_next = fo.cold ? dt2_x11[DT2_W+3:35] : '0;
        end
        else
        begin
            s4_ti_next = fo.cold ? dt2_x3[DT2_W+1:33] : {5'b0, fo.dt2[DT2_W-1:36]};
        end
    end

    // Stage 5: offset and sensitivity corrections, final temperature
    always_comb
    begin
        dv = {2'b0, s4_dev2_reg};
        lw = {2'b0, s4_low2_reg};
        s5_tout_next = $signed({s4_temp_reg[TEMP_W-1], s4_temp_reg}) - $signed({4'b0, s4_ti_reg});
        s5_offi_next  = '0;
        s5_sensi_next = '0;
        if (model == MODEL_LOW_RANGE)
        begin
            if (s4_cold_reg)
            begin
                s5_offi_next  = ((dv << 5) - dv) >> 3;
                s5_sensi_next = ((dv << 6) - dv) >> 5;
            end
        end
        else if (s4_cold_reg)
        begin
            s5_offi_next  = (((dv << 1) + dv) >> 1) + (s4_vcold_reg ? ((lw << 3) - lw) : '0);
            s5_sensi_next = (((dv << 2) + dv) >> 3) + (s4_vcold_reg ? (lw << 2) : '0);
        end
        else
        begin
            s5_offi_next = dv >> 4;
        end
    end

    // Stage 6: subtract the corrections
    always_comb
    begin
        co_next.d1       = s5_d1_reg;
        co_next.temp_out = s5_tout_reg;
        co_next.sens_adj = $signed({{(ADJ_W-OFF_W){s5_sens_reg[OFF_W-1]}}, s5_sens_reg})
                           - $signed(s5_sensi_reg);
        co_next.off_adj  = $signed({{(ADJ_W-OFF_W){s5_off_reg[OFF_W-1]}}, s5_off_reg})
                           - $signed(s5_offi_reg);
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            co_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= fo_valid;
            s5_valid_reg <= s4_valid_reg;
            co_valid_reg <= s5_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        s4_d1_reg    <= fo.d1;
        s4_temp_reg  <= fo.temp;
        s4_ti_reg    <= s4_ti_next;
        s4_dev2_reg  <= s4_dev2_next;
        s4_low2_reg  <= s4_low2_next;
        s4_cold_reg  <= fo.cold;
        s4_vcold_reg <= fo.vcold;
        s4_off_reg   <= fo.off;
        s4_sens_reg  <= fo.sens;
        s5_d1_reg    <= s4_d1_reg;
        s5_tout_reg  <= s5_tout_next;
        s5_offi_reg  <= s5_offi_next;
        s5_sensi_reg <= s5_sensi_next;
        s5_off_reg   <= s4_off_reg;
        s5_sens_reg  <= s4_sens_reg;
        co_reg       <= co_next;
    end

    assign co_valid = co_valid_reg;
    assign co       = co_reg;

endmodule

[rtl/ptc_press.sv]
// Pressure stages: split multiply of D1 by corrected sensitivity, scaling,
// offset subtraction and saturation. Five register stages. Depends on ptc_pkg.
`timescale 1ns / 1ps

module ptc_press
    import ptc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    co_valid,
    input  ptc_corr_t               co,
    input  logic                    model,
    output logic                    done,
    output logic signed [OUT_W-1:0] temp_centideg,
    output logic signed [OUT_W-1:0] pressure_units
);

    localparam int LO_W = 21;
    localparam logic signed [PROD_W-1:0] BIAS_21 = 67'sd2097151;
    localparam logic signed [PROD_W-1:0] ZERO_PR = 67'sd0;
    localparam logic signed [V_W-1:0]    BIAS_13 = 47'sd8191;
    localparam logic signed [V_W-1:0]    BIAS_15 = 47'sd32767;
    localparam logic signed [V_W-1:0]    ZERO_V  = 47'sd0;
    localparam logic signed [OUT_W-1:0]  SAT_MAX = 32'sh7FFFFFFF;
    localparam logic signed [OUT_W-1:0]  SAT_MIN = 32'sh80000000;

    logic                      s7_valid_reg;
    logic [PP_LO_W-1:0]        s7_pplo_reg;
    logic signed [PP_HI_W-1:0] s7_pphi_reg;
    logic signed [TOUT_W-1:0]  s7_tout_reg;
    logic signed [ADJ_W-1:0]   s7_off_reg;
    logic [PP_LO_W-1:0]        s7_pplo_next;
    logic signed [PP_HI_W-1:0] s7_pphi_next;

    logic                      s8_valid_reg;
    logic signed [PROD_W-1:0]  s8_prod_reg;
    logic signed [TOUT_W-1:0]  s8_tout_reg;
    logic signed [ADJ_W-1:0]   s8_off_reg;
    logic signed [PROD_W-1:0]  s8_prod_next;

    logic                      s9_valid_reg;
    logic signed [Q2_W-1:0]    s9_q2_reg;
    logic signed [TOUT_W-1:0]  s9_tout_reg;
    logic signed [ADJ_W-1:0]   s9_off_reg;
    logic signed [PROD_W-1:0]  s9_bias;

    logic                      s10_valid_reg;
    logic signed [V_W-1:0]     s10_v_reg;
    logic signed [TOUT_W-1:0]  s10_tout_reg;
    logic signed [V_W-1:0]     s10_v_next;

    logic                      done_reg;
    logic signed [OUT_W-1:0]   temp_reg;
    logic signed [OUT_W-1:0]   pres_reg;
    logic signed [OUT_W-1:0]   pres_next;
    logic signed [V_W-1:0]     v_b13;
    logic signed [V_W-1:0]     v_b15;
    logic signed [PRES_W-1:0]  pres_full;

    // Stage 7: partial products over the low and high halves of the sensitivity
    assign s7_pplo_next = co.d1 * co.sens_adj[LO_W-1:0];
    assign s7_pphi_next = $signed({1'b0, co.d1}) * $signed(co.sens_adj[ADJ_W-1:LO_W]);

    // Stage 8: recombine
    assign s8_prod_next = $signed({s7_pphi_reg, {LO_W{1'b0}}})
                          + $signed({{(PROD_W-PP_LO_W){1'b0}}, s7_pplo_reg});

    // Stage 9: divide by 2^21 toward zero
    assign s9_bias = s8_prod_reg + (s8_prod_reg[PROD_W-1] ? BIAS_21 : ZERO_PR);

    // Stage 10: subtract the corrected offset
    assign s10_v_next = $signed({s9_q2_reg[Q2_W-1], s9_q2_reg})
                        - $signed({{(V_W-ADJ_W){s9_off_reg[ADJ_W-1]}}, s9_off_reg});

    // Stage 11: final scale toward zero, then saturate to 32 bits
    always_comb
    begin
        v_b13 = s10_v_reg + (s10_v_reg[V_W-1] ? BIAS_13 : ZERO_V);
        v_b15 = s10_v_reg + (s10_v_reg[V_W-1] ? BIAS_15 : ZERO_V);
        if (model == MODEL_LOW_RANGE)
        begin
            pres_full = {{2{v_b15[V_W-1]}}, v_b15[V_W-1:15]};
        end
        else
        begin
            pres_full = v_b13[V_W-1:13];
        end
        if ((pres_full[PRES_W-1:OUT_W-1] == '0) || (pres_full[PRES_W-1:OUT_W-1] == '1))
        begin
            pres_next = pres_full[OUT_W-1:0];
        end
        else
        begin
            pres_next = pres_full[PRES_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            s10_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            s7_valid_reg  <= co_valid;
            s8_valid_reg  <= s7_valid_reg;
            s9_valid_reg  <= s8_valid_reg;
            s10_valid_reg <= s9_valid_reg;
            done_reg      <= s10_valid_reg;
        end
    end

    // Advance payload; the temperature always fits in 32 bits
    always_ff @(posedge clk)
    begin
        s7_pplo_reg  <= s7_pplo_next;
        s7_pphi_reg  <= s7_pphi_next;
        s7_tout_reg  <= co.temp_out;
        s7_off_reg   <= co.off_adj;
        s8_prod_reg  <= s8_prod_next;
        s8_tout_reg  <= s7_tout_reg;
        s8_off_reg   <= s7_off_reg;
        s9_q2_reg    <= s9_bias[PROD_W-1:LO_W];
        s9_tout_reg  <= s8_tout_reg;
        s9_off_reg   <= s8_off_reg;
        s10_v_reg    <= s10_v_next;
        s10_tout_reg <= s9_tout_reg;
        temp_reg     <= {{(OUT_W-TOUT_W){s10_tout_reg[TOUT_W-1]}}, s10_tout_reg};
        pres_reg     <= pres_next;
    end

    assign done           = done_reg;
    assign temp_centideg  = temp_reg;
    assign pressure_units = pres_reg;

endmodule

[rtl/pressure_temp_compensation_unit.sv]
// Top level of the pressure/temperature compensation pipeline: calibration
// registers and the three pipeline sections. Depends on ptc_pkg, ptc_front,
// ptc_corr and ptc_press.
//
// Usage:
//   A reading pair (raw_pressure, raw_temperature) is taken at each rising edge
//   with start high and busy low. busy stays low: one pair is taken every cycle.
//   Each pair yields one result, shown on temp_centideg and pressure_units for
//   one cycle with done high. Results come out in the order the pairs went in;
//   the receiver cannot stall the pipeline.
//   There are eleven register stages, among them the calibration products,
//   the squares, and the 24 x 42 bit pressure product split over two stages.
//   Calibration words and the model select are to be written on the cfg channel
//   (cfg_index, cfg_data, beat on cfg_valid with cfg_ready, always ready) while
//   no result is pending; the block does not enforce this. An unknown index is
//   dropped. Register 6 keeps bit 0.
//   Reset clears all calibration registers and every pipeline valid bit, so no
//   done pulse follows reset until new pairs are taken.
`timescale 1ns / 1ps

module pressure_temp_compensation_unit
    import ptc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [RAW_W-1:0]        raw_pressure,
    input  logic [RAW_W-1:0]        raw_temperature,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CAL_W-1:0]        cfg_data,
    output logic                    done,
    output logic signed [OUT_W-1:0] temp_centideg,
    output logic signed [OUT_W-1:0] pressure_units
);

    ptc_cal_t   cal_reg;
    ptc_cal_t   cal_next;
    logic       accept;
    logic       fo_valid;
    ptc_front_t fo;
    logic       co_valid;
    ptc_corr_t  co;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    // Decode a configuration beat
    always_comb
    begin
        cal_next = cal_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SENS:     cal_next.sens     = cfg_data;
                REG_OFFSET:   cal_next.offset   = cfg_data;
                REG_TCS:      cal_next.tcs      = cfg_data;
                REG_TCO:      cal_next.tco      = cfg_data;
                REG_TREF:     cal_next.tref     = cfg_data;
                REG_TEMPSENS: cal_next.tempsens = cfg_data;
                REG_MODEL:    cal_next.model    = cfg_data[0];
                default:      cal_next          = cal_reg;
            endcase
        end
    end

    // Hold calibration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    ptc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .d1_in    (raw_pressure),
        .d2_in    (raw_temperature),
        .cal      (cal_reg),
        .fo_valid (fo_valid),
        .fo       (fo)
    );

    ptc_corr u_corr (
        .clk      (clk),
        .rst_n    (rst_n),
        .fo_valid (fo_valid),
        .fo       (fo),
        .model    (cal_reg.model),
        .co_valid (co_valid),
        .co       (co)
    );

    ptc_press u_press (
        .clk            (clk),
        .rst_n          (rst_n),
        .co_valid       (co_valid),
        .co             (co),
        .model          (cal_reg.model),
        .done           (done),
        .temp_centideg  (temp_centideg),
        .pressure_units (pressure_units)
    );

endmodule
